### sv/pstq_pkg.sv
// Shared definitions for the prefix-sum tree block: field widths, codes,
// controller states and the command/status bundles between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pstq_pkg;

   // Fixed field widths
   localparam int DATA_W = 32;
   localparam int IDX_W  = 10;
   localparam int CNT_W  = 11;

   // Entry count after reset
   localparam logic [CNT_W-1:0] CSR_RESET = 11'd1024;

   // Operation codes
   localparam logic OP_SET   = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // Status codes
   localparam logic STAT_OK    = 1'b0;
   localparam logic STAT_RANGE = 1'b1;

   // Controller states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RAW_RD,
      ST_RAW_WR,
      ST_WALK_UP,
      ST_WALK_HI,
      ST_WALK_LO,
      ST_DONE
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic clear;      // zero one entry of both stores, advance sweep
      logic accept;     // latch request fields, set up high prefix walk
      logic raw_wr;     // form delta, store new value, set up update walk
      logic walk_step;  // one node of the active tree walk
      logic lo_load;    // set up the subtracting prefix walk
      logic rsp_load;   // load result register
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic clr_last;   // sweep is at the last entry
      logic req_err;    // offered request has an index out of range
      logic req_query;  // offered request is a query
      logic walk_busy;  // walk has nodes left or a read in flight
   } stat_type;

endpackage

`default_nettype wire

### sv/pstq_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module pstq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### sv/pstq_ctrl.sv
// Controller for the prefix-sum tree block: clearing sweep, item sequencing,
// walk control and the result valid flag. Uses pstq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pstq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   input  pstq_pkg::stat_type stat,
   output pstq_pkg::cmd_type  cmd
);

   pstq_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // State and result flag registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pstq_pkg::ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         pstq_pkg::ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (stat.clr_last) begin
               state_in = pstq_pkg::ST_IDLE;
            end
         end
         pstq_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (stat.req_err) begin
                  state_in = pstq_pkg::ST_DONE;
               end else if (stat.req_query) begin
                  state_in = pstq_pkg::ST_WALK_HI;
               end else begin
                  state_in = pstq_pkg::ST_RAW_RD;
               end
            end
         end
         pstq_pkg::ST_RAW_RD: begin
            state_in = pstq_pkg::ST_RAW_WR;
         end
         pstq_pkg::ST_RAW_WR: begin
            cmd.raw_wr = 1'b1;
            state_in   = pstq_pkg::ST_WALK_UP;
         end
         pstq_pkg::ST_WALK_UP: begin
            cmd.walk_step = 1'b1;
            if (!stat.walk_busy) begin
               state_in = pstq_pkg::ST_DONE;
            end
         end
         pstq_pkg::ST_WALK_HI: begin
            cmd.walk_step = 1'b1;
            if (!stat.walk_busy) begin
               cmd.lo_load = 1'b1;
               state_in    = pstq_pkg::ST_WALK_LO;
            end
         end
         pstq_pkg::ST_WALK_LO: begin
            cmd.walk_step = 1'b1;
            if (!stat.walk_busy) begin
               state_in = pstq_pkg::ST_DONE;
            end
         end
         pstq_pkg::ST_DONE: begin
            // result register free or emptying this cycle
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.rsp_load = 1'b1;
               state_in     = pstq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pstq_pkg::ST_IDLE;
         end
      endcase
   end

   // Result valid: set on load, cleared on transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

### sv/pstq_dpath.sv
// Datapath for the prefix-sum tree block: entry count register, item latches,
// tree and value stores, tree walker, accumulator and result register.
// Uses pstq_pkg and pstq_ram.
`timescale 1ns / 1ps
`default_nettype none

module pstq_dpath #(
   parameter int MAX_ENTRIES = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [pstq_pkg::CNT_W-1:0]         csr_wr_data,
   input  logic                               req_op,
   input  logic [pstq_pkg::IDX_W-1:0]         req_first_index,
   input  logic [pstq_pkg::IDX_W-1:0]         req_last_index,
   input  logic signed [pstq_pkg::DATA_W-1:0] req_new_value,
   input  pstq_pkg::cmd_type                  cmd,
   output pstq_pkg::stat_type                 stat,
   output logic                               rsp_status,
   output logic signed [pstq_pkg::DATA_W-1:0] rsp_range_sum
);

   localparam int AW   = $clog2(MAX_ENTRIES);
   localparam int PW   = AW + 2;  // node position, room for the step past the top
   localparam int CMW  = $clog2(MAX_ENTRIES + 1);
   localparam int CNTW = (CMW > pstq_pkg::CNT_W) ? CMW : pstq_pkg::CNT_W;

   // Configuration and sweep
   logic [pstq_pkg::CNT_W-1:0]  csr_ff, csr_in;
   logic [AW-1:0]               clr_addr_ff, clr_addr_in;
   // Latched item
   logic                        op_ff, op_in;
   logic                        err_ff, err_in;
   logic [pstq_pkg::IDX_W-1:0]  first_ff, first_in;
   logic [pstq_pkg::DATA_W-1:0] val_ff, val_in;
   // Walker
   logic [PW-1:0]               pos_ff, pos_in;
   logic [PW-1:0]               wpos_ff, wpos_in;
   logic                        pend_ff, pend_in;
   logic                        up_ff, up_in;
   logic                        sub_ff, sub_in;
   logic [pstq_pkg::DATA_W-1:0] acc_ff, acc_in;
   logic [pstq_pkg::DATA_W-1:0] delta_ff, delta_in;
   // Result register
   logic                        rsp_status_ff, rsp_status_in;
   logic [pstq_pkg::DATA_W-1:0] rsp_sum_ff, rsp_sum_in;

   logic [CNTW-1:0]             count_eff;
   logic                        first_bad, last_bad, req_err;
   logic                        walk_active;
   logic [PW-1:0]               pos_up, pos_down;
   logic [pstq_pkg::DATA_W-1:0] tree_rdata, raw_rdata;
   logic                        tree_we, raw_we;
   logic [AW-1:0]               tree_waddr, raw_waddr;
   logic [pstq_pkg::DATA_W-1:0] tree_wdata, raw_wdata;

   // Stores
   pstq_ram #(.WIDTH(pstq_pkg::DATA_W), .DEPTH(MAX_ENTRIES)) u_tree_ram (
      .clock   (clock),
      .wr_en   (tree_we),
      .wr_addr (tree_waddr),
      .wr_data (tree_wdata),
      .rd_addr (AW'(pos_ff - PW'(1))),
      .rd_data (tree_rdata)
   );

   pstq_ram #(.WIDTH(pstq_pkg::DATA_W), .DEPTH(MAX_ENTRIES)) u_raw_ram (
      .clock   (clock),
      .wr_en   (raw_we),
      .wr_addr (raw_waddr),
      .wr_data (raw_wdata),
      .rd_addr (AW'(first_ff)),
      .rd_data (raw_rdata)
   );

   // Range check on the offered request against the clamped entry count
   always_comb begin
      if (CNTW'(csr_ff) > CNTW'(MAX_ENTRIES)) begin
         count_eff = CNTW'(MAX_ENTRIES);
      end else begin
         count_eff = CNTW'(csr_ff);
      end
      first_bad = CNTW'(req_first_index) >= count_eff;
      last_bad  = CNTW'(req_last_index) >= count_eff;
      req_err   = first_bad || ((req_op == pstq_pkg::OP_QUERY) && last_bad);
   end

   // Walk steps: climb adds the low set bit, descent clears it
   assign pos_up      = pos_ff + (pos_ff & (~pos_ff + PW'(1)));
   assign pos_down    = pos_ff & (pos_ff - PW'(1));
   assign walk_active = up_ff ? (pos_ff <= PW'(MAX_ENTRIES)) : (pos_ff != '0);

   // Store write ports: clearing sweep, tree node update, value record
   always_comb begin
      tree_we    = cmd.clear || (cmd.walk_step && pend_ff && up_ff);
      tree_waddr = cmd.clear ? clr_addr_ff : AW'(wpos_ff - PW'(1));
      tree_wdata = cmd.clear ? '0 : tree_rdata + delta_ff;
      raw_we     = cmd.clear || cmd.raw_wr;
      raw_waddr  = cmd.clear ? clr_addr_ff : AW'(first_ff);
      raw_wdata  = cmd.clear ? '0 : val_ff;
   end

   // Next values
   always_comb begin
      csr_in        = csr_wr_en ? csr_wr_data : csr_ff;
      clr_addr_in   = cmd.clear ? clr_addr_ff + AW'(1) : clr_addr_ff;
      op_in         = op_ff;
      err_in        = err_ff;
      first_in      = first_ff;
      val_in        = val_ff;
      pos_in        = pos_ff;
      wpos_in       = wpos_ff;
      pend_in       = pend_ff;
      up_in         = up_ff;
      sub_in        = sub_ff;
      acc_in        = acc_ff;
      delta_in      = delta_ff;
      rsp_status_in = rsp_status_ff;
      rsp_sum_in    = rsp_sum_ff;

      // one node per cycle, read data lands in the cycle after the address
      if (cmd.walk_step) begin
         pend_in = walk_active;
         wpos_in = pos_ff;
         if (walk_active) begin
            pos_in = up_ff ? pos_up : pos_down;
         end
         if (pend_ff && !up_ff) begin
            acc_in = sub_ff ? acc_ff - tree_rdata : acc_ff + tree_rdata;
         end
      end

      // item latch, prefix walk of last_index set up at once
      if (cmd.accept) begin
         op_in    = req_op;
         err_in   = req_err;
         first_in = req_first_index;
         val_in   = $unsigned(req_new_value);
         pos_in   = PW'(req_last_index) + PW'(1);
         pend_in  = 1'b0;
         up_in    = 1'b0;
         sub_in   = 1'b0;
         acc_in   = '0;
      end

      // set: delta from old value, update walk from node first+1
      if (cmd.raw_wr) begin
         delta_in = val_ff - raw_rdata;
         pos_in   = PW'(first_ff) + PW'(1);
         pend_in  = 1'b0;
         up_in    = 1'b1;
      end

      // query: subtract prefix of first-1, i.e. start at node first
      if (cmd.lo_load) begin
         pos_in  = PW'(first_ff);
         pend_in = 1'b0;
         sub_in  = 1'b1;
      end

      if (cmd.rsp_load) begin
         rsp_status_in = err_ff ? pstq_pkg::STAT_RANGE : pstq_pkg::STAT_OK;
         rsp_sum_in    = ((op_ff == pstq_pkg::OP_QUERY) && !err_ff) ? acc_ff : '0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff      <= pstq_pkg::CSR_RESET;
         clr_addr_ff <= '0;
         pend_ff     <= 1'b0;
         up_ff       <= 1'b0;
         err_ff      <= 1'b0;
      end else begin
         csr_ff      <= csr_in;
         clr_addr_ff <= clr_addr_in;
         pend_ff     <= pend_in;
         up_ff       <= up_in;
         err_ff      <= err_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      first_ff      <= first_in;
      val_ff        <= val_in;
      pos_ff        <= pos_in;
      wpos_ff       <= wpos_in;
      sub_ff        <= sub_in;
      acc_ff        <= acc_in;
      delta_ff      <= delta_in;
      rsp_status_ff <= rsp_status_in;
      rsp_sum_ff    <= rsp_sum_in;
   end

   // Status to controller
   always_comb begin
      stat.clr_last  = clr_addr_ff == AW'(MAX_ENTRIES - 1);
      stat.req_err   = req_err;
      stat.req_query = req_op == pstq_pkg::OP_QUERY;
      stat.walk_busy = walk_active || pend_ff;
   end

   assign rsp_status    = rsp_status_ff;
   assign rsp_range_sum = $signed(rsp_sum_ff);

endmodule

`default_nettype wire

### sv/prefix_sum_tree_point_set_range_query.sv
// Point-set / range-sum block over a binary indexed tree of signed 32-bit entries.
// Top level: joins pstq_ctrl and pstq_dpath. Uses pstq_pkg.
//
// Usage:
//  - Request channel (req_*): op 0 sets entry first_index to new_value, op 1 returns
//    the wrapped sum of entries first_index..last_index. Transfer when req_valid is
//    high and req_stall low.
//  - Response channel (rsp_*): one result per request, status 1 when an index is at
//    or beyond the entry count (nothing changes, sum zero). Sum is zero for a set.
//  - csr_wr_en / csr_wr_data write the entry count (clamped to MAX_ENTRIES); write
//    only while no request is in flight.
//  - One item at a time, one tree node per cycle through the tree store's read port.
//    Set: reads the old value, stores the new one, then walks the update path to the top.
//    Query: walks the prefix path of last_index, then subtracts the prefix of
//    first_index - 1 (no nodes to walk when first_index is 0).
//    Out-of-range item: goes straight to its response.
//  - Reset: both stores are swept to zero, one entry per cycle, with req_stall high
//    throughout; the entry count returns to 1024.
//  - A stalled response holds in its output register; the next request is still
//    taken and worked on, and its result waits until the register frees.
`timescale 1ns / 1ps
`default_nettype none

module prefix_sum_tree_point_set_range_query #(
   parameter int MAX_ENTRIES = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [pstq_pkg::CNT_W-1:0]         csr_wr_data,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_op,
   input  logic [pstq_pkg::IDX_W-1:0]         req_first_index,
   input  logic [pstq_pkg::IDX_W-1:0]         req_last_index,
   input  logic signed [pstq_pkg::DATA_W-1:0] req_new_value,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_status,
   output logic signed [pstq_pkg::DATA_W-1:0] rsp_range_sum
);

   pstq_pkg::cmd_type  cmd;
   pstq_pkg::stat_type stat;

   // Sequencer
   pstq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Stores, walker and result register
   pstq_dpath #(.MAX_ENTRIES(MAX_ENTRIES)) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_op          (req_op),
      .req_first_index (req_first_index),
      .req_last_index  (req_last_index),
      .req_new_value   (req_new_value),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_status      (rsp_status),
      .rsp_range_sum   (rsp_range_sum)
   );

endmodule

`default_nettype wire

### sv/pstq_checker.sv
// Port-level checks for the prefix-sum tree block, bound to its top level.
// Uses pstq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pstq_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_stall,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic                               rsp_status,
   input logic signed [pstq_pkg::DATA_W-1:0] rsp_range_sum
);

   // Stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) && $stable(rsp_range_sum))
      else $error("stalled response changed");

   // Error responses carry a zero sum
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == pstq_pkg::STAT_RANGE) |-> rsp_range_sum == '0)
      else $error("error response with nonzero sum");

   // Clearing sweep blocks requests right after reset
   a_clear_stall: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("request side open during clearing sweep");

   // No response is pending after reset
   a_reset_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // One item at a time: a request transfer closes the request side
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request taken while one is in flight");

endmodule

bind prefix_sum_tree_point_set_range_query pstq_checker u_pstq_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_status    (rsp_status),
   .rsp_range_sum (rsp_range_sum)
);

`default_nettype wire

### tb/prefix_sum_tree_point_set_range_query_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for prefix_sum_tree_point_set_range_query: set and range-sum
// transfers, each checked against a local binary indexed tree. Depends on pstq_pkg and the RTL.
module prefix_sum_tree_point_set_range_query_tb;

   localparam int IDX_W          = pstq_pkg::IDX_W;
   localparam int DATA_W         = pstq_pkg::DATA_W;
   localparam int CNT_W          = pstq_pkg::CNT_W;
   localparam int MAX_ENTRIES    = 1024;
   localparam int SETTLE_CYCLES  = 32;
   localparam int HOLD_CYCLES    = 200;
   localparam int WATCHDOG_LIMIT = 8000;

   typedef struct {
      logic              op;
      logic [IDX_W-1:0]  first_idx;
      logic [IDX_W-1:0]  last_idx;
      logic [DATA_W-1:0] value;
   } tree_req_type;

   typedef struct {
      logic              status;
      logic [DATA_W-1:0] range_sum;
   } tree_rsp_type;

   logic                     clock           = 1'b0;
   logic                     reset           = 1'b1;
   logic                     csr_wr_en       = 1'b0;
   logic [CNT_W-1:0]         csr_wr_data     = '0;
   logic                     req_valid       = 1'b0;
   logic                     req_stall;
   logic                     req_op          = pstq_pkg::OP_SET;
   logic [IDX_W-1:0]         req_first_index = '0;
   logic [IDX_W-1:0]         req_last_index  = '0;
   logic signed [DATA_W-1:0] req_new_value   = '0;
   logic                     rsp_valid;
   logic                     rsp_stall       = 1'b0;
   logic                     rsp_status;
   logic signed [DATA_W-1:0] rsp_range_sum;

   // Local tree image: node sums, entry values, entry count
   logic [DATA_W-1:0] node_sum  [1:MAX_ENTRIES];
   logic [DATA_W-1:0] entry_val [0:MAX_ENTRIES-1];
   logic [CNT_W-1:0]  entry_count;

   tree_rsp_type pending_results [$];
   int        mismatches  = 0;
   int        idle_cycles = 0;
   bit        req_gaps    = 1'b1;
   bit        rsp_gaps    = 1'b1;
   bit        hold_rsp    = 1'b0;
   bit        hold_active = 1'b0;

   prefix_sum_tree_point_set_range_query #(
      .MAX_ENTRIES(MAX_ENTRIES)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_first_index (req_first_index),
      .req_last_index  (req_last_index),
      .req_new_value   (req_new_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_range_sum   (rsp_range_sum)
   );

   always #2 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic int unsigned active_entries();
      return (entry_count > MAX_ENTRIES) ? MAX_ENTRIES : entry_count;
   endfunction

   // wrapped sum of entries 0..idx
   function automatic logic [DATA_W-1:0] prefix_sum(int unsigned idx);
      int unsigned       pos;
      logic [DATA_W-1:0] acc;
      pos = idx + 1;
      acc = '0;
      while (pos > 0) begin
         acc += node_sum[pos];
         pos &= pos - 1;
      end
      return acc;
   endfunction

   // update path always spans the full tree
   function automatic void add_along_path(int unsigned idx, logic [DATA_W-1:0] delta);
      int unsigned pos;
      pos = idx + 1;
      while (pos <= MAX_ENTRIES) begin
         node_sum[pos] += delta;
         pos += pos & (~pos + 1);
      end
   endfunction

   function automatic tree_rsp_type tree_apply(tree_req_type item);
      tree_rsp_type      r;
      int unsigned       n;
      logic [DATA_W-1:0] lower;
      n           = active_entries();
      r.status    = pstq_pkg::STAT_OK;
      r.range_sum = '0;
      if (item.op == pstq_pkg::OP_SET) begin
         if (item.first_idx >= n) begin
            r.status = pstq_pkg::STAT_RANGE;
         end else begin
            add_along_path(item.first_idx, item.value - entry_val[item.first_idx]);
            entry_val[item.first_idx] = item.value;
         end
      end else begin
         if (item.first_idx >= n || item.last_idx >= n) begin
            r.status = pstq_pkg::STAT_RANGE;
         end else begin
            lower       = (item.first_idx == 0) ? '0 : prefix_sum(item.first_idx - 1);
            r.range_sum = prefix_sum(item.last_idx) - lower;
         end
      end
      return r;
   endfunction

   function automatic void clear_tree();
      for (int i = 1; i <= MAX_ENTRIES; i++) node_sum[i] = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) entry_val[i] = '0;
      entry_count = pstq_pkg::CSR_RESET;
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   function automatic tree_req_type make_item(logic op, int f, int l, logic [DATA_W-1:0] v);
      tree_req_type it;
      it.op        = op;
      it.first_idx = IDX_W'(f);
      it.last_idx  = IDX_W'(l);
      it.value     = v;
      return it;
   endfunction

   // mostly in range, some anywhere in the field
   function automatic logic [IDX_W-1:0] rand_index(int unsigned n);
      if (n == 0 || $urandom_range(0, 7) == 0) return IDX_W'($urandom_range(0, 1023));
      return IDX_W'($urandom_range(0, n - 1));
   endfunction

   function automatic logic [DATA_W-1:0] rand_value();
      case ($urandom_range(0, 7))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return $urandom_range(0, 32) - 16;
         3:       return '0;
         default: return $urandom;
      endcase
   endfunction

   function automatic tree_req_type rand_item();
      tree_req_type     it;
      int unsigned      n;
      logic [IDX_W-1:0] tmp;
      n            = active_entries();
      it.op        = $urandom_range(0, 1) ? pstq_pkg::OP_QUERY : pstq_pkg::OP_SET;
      it.first_idx = rand_index(n);
      it.last_idx  = rand_index(n);
      it.value     = rand_value();
      // most queries ordered, some reversed
      if (it.op == pstq_pkg::OP_QUERY && it.first_idx > it.last_idx &&
          $urandom_range(0, 3) != 0) begin
         tmp          = it.first_idx;
         it.first_idx = it.last_idx;
         it.last_idx  = tmp;
      end
      return it;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // offer one item, hold it until the transfer, record the expected result
   task automatic send_item(tree_req_type item);
      int gap;
      req_valid       <= 1'b1;
      req_op          <= item.op;
      req_first_index <= item.first_idx;
      req_last_index  <= item.last_idx;
      req_new_value   <= item.value;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      pending_results.push_back(tree_apply(item));
      gap = req_gaps ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // entry count written only with the block idle
   task automatic write_count(logic [CNT_W-1:0] v);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      entry_count  = v;
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_directed();
      send_item(make_item(pstq_pkg::OP_SET, 0, 0, 32'h7FFF_FFFF));
      send_item(make_item(pstq_pkg::OP_SET, 1023, 0, 32'h8000_0000));
      send_item(make_item(pstq_pkg::OP_SET, 512, 0, 32'hFFFF_FFFF));
      send_item(make_item(pstq_pkg::OP_SET, 0, 0, 32'd5));
      send_item(make_item(pstq_pkg::OP_QUERY, 0, 0, '0));
      send_item(make_item(pstq_pkg::OP_QUERY, 0, 1023, '0));
      send_item(make_item(pstq_pkg::OP_QUERY, 1023, 1023, '0));
      // first above last: negated middle sum, or zero when adjacent
      send_item(make_item(pstq_pkg::OP_QUERY, 600, 100, '0));
      send_item(make_item(pstq_pkg::OP_QUERY, 513, 512, '0));
      send_item(make_item(pstq_pkg::OP_QUERY, 1023, 0, '0));
      // unused fields carry junk
      send_item(make_item(pstq_pkg::OP_SET, 300, 1023, 32'h1234_5678));
      send_item(make_item(pstq_pkg::OP_QUERY, 1, 1022, 32'hFFFF_FFFF));
   endtask

   task automatic test_count_edges();
      // zero entries: everything out of range
      write_count(11'd0);
      send_item(make_item(pstq_pkg::OP_SET, 0, 0, 32'd9));
      send_item(make_item(pstq_pkg::OP_QUERY, 0, 0, '0));
      write_count(11'd1);
      send_item(make_item(pstq_pkg::OP_SET, 0, 0, 32'hFFFF_FFF9));
      send_item(make_item(pstq_pkg::OP_QUERY, 0, 0, '0));
      send_item(make_item(pstq_pkg::OP_SET, 1, 0, 32'd3));
      send_item(make_item(pstq_pkg::OP_QUERY, 0, 1, '0));
      // count above the maximum clamps
      write_count(11'h7FF);
      send_item(make_item(pstq_pkg::OP_QUERY, 0, 1023, '0));
      send_item(make_item(pstq_pkg::OP_SET, 1023, 0, 32'h7FFF_FFFF));
      write_count(11'd16);
      send_item(make_item(pstq_pkg::OP_QUERY, 0, 20, '0));
      send_item(make_item(pstq_pkg::OP_SET, 500, 0, 32'd1));
      send_item(make_item(pstq_pkg::OP_QUERY, 15, 15, '0));
      // entries above a lowered count come back intact
      write_count(11'd1024);
      send_item(make_item(pstq_pkg::OP_QUERY, 1023, 1023, '0));
   endtask

   task automatic test_random_mix(logic [CNT_W-1:0] count_val, int n_items);
      write_count(count_val);
      repeat (n_items) send_item(rand_item());
   endtask

   // receiver holds off, sender keeps offering until input stalls
   task automatic test_backpressure();
      req_gaps = 1'b0;
      hold_rsp = 1'b1;
      while (!hold_active) @(posedge clock);
      repeat (30) send_item(rand_item());
      req_gaps = 1'b1;
   endtask

   task automatic test_drain_pause();
      repeat (10) send_item(rand_item());
      wait_drained();
      repeat (10) send_item(rand_item());
   endtask

   task automatic test_back_to_back();
      req_gaps = 1'b0;
      rsp_gaps = 1'b0;
      repeat (50) send_item(rand_item());
      req_gaps = 1'b1;
      rsp_gaps = 1'b1;
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      clear_tree();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      // clearing sweep after reset
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);

      test_directed();
      test_count_edges();
      test_random_mix(CNT_W'($urandom_range(1, 32)), 150);
      test_random_mix(11'd1024, 150);
      test_random_mix(CNT_W'($urandom_range(1, 2047)), 100);
      test_random_mix(11'h7FF, 50);
      test_backpressure();
      test_drain_pause();
      test_back_to_back();

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("[prefix_sum_tree_point_set_range_query] OK");
      end else begin
         $display("[prefix_sum_tree_point_set_range_query] ERROR");
      end
      $finish;
   end

   // ---------------------------------------------------------------- receiver pacing

   initial begin : rsp_pacer
      int len;
      int roll;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_stall   <= 1'b1;
            hold_active  = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall   <= 1'b0;
            hold_active  = 1'b0;
            hold_rsp     = 1'b0;
         end else if (!rsp_gaps) begin
            rsp_stall <= 1'b0;
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 65) begin
               rsp_stall <= 1'b0;
               len = $urandom_range(1, 8);
            end else if (roll < 93) begin
               rsp_stall <= 1'b1;
               len = $urandom_range(1, 3);
            end else begin
               rsp_stall <= 1'b1;
               len = $urandom_range(15, 50);
            end
            repeat (len - 1) @(posedge clock);
         end
      end
   end

   // ---------------------------------------------------------------- result check

   always @(posedge clock) begin : rsp_check
      tree_rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (pending_results.size() == 0) begin
            $error("result transfer with nothing pending: status %0d range_sum %0d",
                   rsp_status, rsp_range_sum);
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_status);
               mismatches++;
            end
            if (rsp_range_sum !== want.range_sum) begin
               $error("range_sum: expected %0d, actual %0d",
                      $signed(want.range_sum), rsp_range_sum);
               mismatches++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- watchdog

   always @(posedge clock) begin : watchdog
      if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[prefix_sum_tree_point_set_range_query] ERROR");
            $finish;
         end
      end
   end

endmodule
